// ===== design/erc_pkg.sv =====
// shared types, constants and helpers for the euler rotation unit
`default_nettype none
package erc_pkg;
  localparam int CordicStepsDef = 16;
  localparam int AngleBitsDef   = 16;
  localparam int AtanCount      = 30;
  localparam logic signed [33:0] GainQ30 = 34'sd652032874;
  localparam logic signed [33:0] OneQ30  = 34'sd1073741824;

  typedef enum logic [2:0] {
    ORD_XYZ = 3'd0, ORD_XZY = 3'd1, ORD_YXZ = 3'd2,
    ORD_YZX = 3'd3, ORD_ZXY = 3'd4, ORD_ZYX = 3'd5
  } order_t;

  typedef logic signed [31:0] q30_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000; 5'd1:  v = 32'h12E4051D; 5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4; 5'd4:  v = 32'h028B0D43; 5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E; 5'd7:  v = 32'h00517C55; 5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2E; 5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3; 5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C; 5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F; 5'd19: v = 32'h00000517; 5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145; 5'd22: v = 32'h000000A2; 5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028; 5'd25: v = 32'h00000014; 5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005; 5'd28: v = 32'h00000002; 5'd29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // clamp a wide value to [-2^30, 2^30]
  function automatic q30_t clamp_q30(input logic signed [67:0] v);
    q30_t r;
    if (v > 68'sd1073741824) r = 32'sd1073741824;
    else if (v < -68'sd1073741824) r = -32'sd1073741824;
    else r = v[31:0];
    return r;
  endfunction

  // round half up from q30 product sum, then clamp
  function automatic q30_t round_q30(input logic signed [67:0] acc);
    logic signed [67:0] t;
    t = (acc + 68'sd536870912) >>> 30;
    return clamp_q30(t);
  endfunction
endpackage
`default_nettype wire

// ===== design/erc_cell.sv =====
// one cordic micro-rotation cell for three angles side by side
`default_nettype none
module erc_cell
  import erc_pkg::*;
#(
  parameter int STEP = 0
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               vld_i,
  input  wire logic signed [33:0] x_i [3],
  input  wire logic signed [33:0] y_i [3],
  input  wire logic signed [33:0] z_i [3],
  input  wire logic [2:0]         flip_i,
  input  wire logic [98:0]        side_i,
  output logic                    vld_o,
  output logic signed [33:0]      x_o [3],
  output logic signed [33:0]      y_o [3],
  output logic signed [33:0]      z_o [3],
  output logic [2:0]              flip_o,
  output logic [98:0]             side_o
);
  localparam logic [4:0] Idx = 5'(STEP);
  logic signed [33:0] x_nxt [3];
  logic signed [33:0] y_nxt [3];
  logic signed [33:0] z_nxt [3];
  logic signed [33:0] at;

  always_comb begin
    at = $signed({2'b00, atan_lut(Idx)});
    for (int a = 0; a < 3; a++) begin
      if (!z_i[a][33]) begin
        x_nxt[a] = x_i[a] - (y_i[a] >>> STEP);
        y_nxt[a] = y_i[a] + (x_i[a] >>> STEP);
        z_nxt[a] = z_i[a] - at;
      end else begin
        x_nxt[a] = x_i[a] + (y_i[a] >>> STEP);
        y_nxt[a] = y_i[a] - (x_i[a] >>> STEP);
        z_nxt[a] = z_i[a] + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (adv) begin
      vld_o <= vld_i;
    end
    if (adv) begin
      x_o    <= x_nxt;
      y_o    <= y_nxt;
      z_o    <= z_nxt;
      flip_o <= flip_i;
      side_o <= side_i;
    end
  end
endmodule
`default_nettype wire

// ===== design/erc_mat.sv =====
// matrix product of the three elementary rotations, one output row per beat
`default_nettype none
module erc_mat
  import erc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire q30_t              sc_i [6],
  input  wire logic [98:0]       side_i,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_row_number,
  output q30_t                   out_entry_col0,
  output q30_t                   out_entry_col1,
  output q30_t                   out_entry_col2,
  output logic signed [31:0]     out_offset_col3,
  output logic                   out_last_row
);
  // phase 0: first product, phase 1: second, phase 2: rows out
  logic [2:0] ph_r;
  q30_t a_r [3][3];
  q30_t b_r [3][3];
  q30_t c_r [3][3];
  q30_t p_r [3][3];
  logic signed [31:0] ctr_r [3];
  logic [1:0] row_r;
  logic busy_r, ov_r;
  q30_t e0_r, e1_r, e2_r;
  logic signed [31:0] off_r;
  q30_t rx [3][3];
  q30_t ry [3][3];
  q30_t rz [3][3];
  q30_t pm [3][3];
  q30_t m1a [3][3];
  q30_t m1b [3][3];
  logic signed [67:0] acc;
  logic signed [67:0] t;
  logic take, emit, load;

  always_comb begin
    rx = '{'{32'sd1073741824, 0, 0}, '{0, sc_i[1], -sc_i[0]}, '{0, sc_i[0], sc_i[1]}};
    ry = '{'{sc_i[3], 0, sc_i[2]}, '{0, 32'sd1073741824, 0}, '{-sc_i[2], 0, sc_i[3]}};
    rz = '{'{sc_i[5], -sc_i[4], 0}, '{sc_i[4], sc_i[5], 0}, '{0, 0, 32'sd1073741824}};
    unique case (side_i[98:96])
      ORD_XZY: begin m1a = rz; m1b = rx; end
      ORD_YXZ: begin m1a = rx; m1b = ry; end
      ORD_YZX: begin m1a = rz; m1b = ry; end
      ORD_ZXY: begin m1a = rx; m1b = rz; end
      ORD_ZYX: begin m1a = ry; m1b = rz; end
      default: begin m1a = ry; m1b = rx; end
    endcase
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        acc = '0;
        for (int m = 0; m < 3; m++) acc += 68'(a_r[r][m]) * 68'(b_r[m][k]);
        pm[r][k] = round_q30(acc);
      end
    end
    acc = '0;
    for (int k = 0; k < 3; k++) acc += 68'(p_r[row_r][k]) * 68'(ctr_r[k]);
    t = 68'(ctr_r[row_r]) - ((acc + 68'sd536870912) >>> 30);
  end

  assign emit = ov_r && out_ready;
  assign in_ready = !busy_r;
  assign take = in_valid && in_ready;
  // a row goes into the output register when it is empty or being drained
  assign load = busy_r && (ph_r == 3'd2) && (!ov_r || emit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
      ph_r   <= '0;
      row_r  <= '0;
    end else begin
      if (load) ov_r <= 1'b1;
      else if (emit) ov_r <= 1'b0;
      if (take) begin
        busy_r <= 1'b1;
        ph_r   <= 3'd0;
        row_r  <= 2'd0;
      end else if (busy_r) begin
        if (ph_r == 3'd0) ph_r <= 3'd1;
        else if (ph_r == 3'd1) ph_r <= 3'd2;
        else if (load) begin
          row_r <= row_r + 2'd1;
          if (row_r == 2'd2) busy_r <= 1'b0;
        end
      end
    end
    if (take) begin
      a_r <= m1a;
      b_r <= m1b;
      unique case (side_i[98:96])
        ORD_XZY, ORD_ZXY: c_r <= ry;
        ORD_YZX, ORD_ZYX: c_r <= rx;
        default: c_r <= rz;
      endcase
      ctr_r <= '{side_i[31:0], side_i[63:32], side_i[95:64]};
    end else if (busy_r && ph_r == 3'd0) begin
      a_r <= c_r;
      b_r <= pm;
    end else if (busy_r && ph_r == 3'd1) begin
      p_r <= pm;
    end
    if (load) begin
      out_row_number <= row_r;
      out_last_row   <= (row_r == 2'd2);
      e0_r <= p_r[row_r][0];
      e1_r <= p_r[row_r][1];
      e2_r <= p_r[row_r][2];
      if (t > 68'sd2147483647) off_r <= 32'h7fffffff;
      else if (t < -68'sd2147483648) off_r <= 32'h80000000;
      else off_r <= t[31:0];
    end
  end

  assign out_valid       = ov_r;
  assign out_entry_col0  = e0_r;
  assign out_entry_col1  = e1_r;
  assign out_entry_col2  = e2_r;
  assign out_offset_col3 = off_r;
endmodule
`default_nettype wire

// ===== design/euler_rotation_about_center_unit.sv =====
// top level: cordic cell chain feeding the matrix build stage
// first row: the input beat passes through the CORDIC_STEPS cells of the chain
// (steps capped at 30), then the two product phases, then the row is registered;
// the other two rows follow one per cycle while out_ready is high
// the matrix stage takes an item, runs its two product phases and sends three row
// beats before it takes the next item
// reset: synchronous active-low rst_n clears all valid flags
`default_nettype none
module euler_rotation_about_center_unit
  import erc_pkg::*;
#(
  parameter int CORDIC_STEPS = CordicStepsDef,
  parameter int ANGLE_BITS   = AngleBitsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [15:0]        in_angle_x,
  input  wire logic [15:0]        in_angle_y,
  input  wire logic [15:0]        in_angle_z,
  input  wire logic signed [31:0] in_pivot_x,
  input  wire logic signed [31:0] in_pivot_y,
  input  wire logic signed [31:0] in_pivot_z,
  input  wire logic [2:0]         in_order_code,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_row_number,
  output logic signed [31:0]      out_entry_col0,
  output logic signed [31:0]      out_entry_col1,
  output logic signed [31:0]      out_entry_col2,
  output logic signed [31:0]      out_offset_col3,
  output logic                    out_last_row
);
  localparam int N = (CORDIC_STEPS > AtanCount) ? AtanCount : CORDIC_STEPS;
  localparam int AB = (ANGLE_BITS > 16) ? 16 : ANGLE_BITS;

  // chain registers, index 0 is the input of cell 0
  logic               v   [N+1];
  logic signed [33:0] xs  [N+1][3];
  logic signed [33:0] ys  [N+1][3];
  logic signed [33:0] zs  [N+1][3];
  logic [2:0]         fl  [N+1];
  logic [98:0]        sd  [N+1];
  logic               adv, m_ready;
  logic [15:0]        ang [3];
  q30_t               sc  [6];

  // chain stalls only when its last stage is full and the matrix stage is busy
  assign adv      = !v[N] || m_ready;
  assign in_ready = adv;
  assign ang      = '{in_angle_x, in_angle_y, in_angle_z};

  // angle to 32-bit turn, fold quadrants two and three by half a turn
  always_comb begin
    logic [31:0] u;
    v[0] = in_valid;
    for (int a = 0; a < 3; a++) begin
      u = 32'(ang[a][AB-1:0]) << (32 - ANGLE_BITS);
      fl[0][a] = (u[31:30] == 2'b01) || (u[31:30] == 2'b10);
      if (fl[0][a]) u = u + 32'h80000000;
      xs[0][a] = GainQ30;
      ys[0][a] = '0;
      zs[0][a] = 34'($signed(u));
    end
    sd[0] = {in_order_code, in_pivot_z, in_pivot_y, in_pivot_x};
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    erc_cell #(.STEP(g)) u_cell (
      .clk, .rst_n, .adv,
      .vld_i(v[g]), .x_i(xs[g]), .y_i(ys[g]), .z_i(zs[g]), .flip_i(fl[g]), .side_i(sd[g]),
      .vld_o(v[g+1]), .x_o(xs[g+1]), .y_o(ys[g+1]), .z_o(zs[g+1]), .flip_o(fl[g+1]),
      .side_o(sd[g+1])
    );
  end

  // undo the fold and clamp: sine then cosine per axis
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sc[2*a]   = clamp_q30(fl[N][a] ? -68'(ys[N][a]) : 68'(ys[N][a]));
      sc[2*a+1] = clamp_q30(fl[N][a] ? -68'(xs[N][a]) : 68'(xs[N][a]));
    end
  end

  erc_mat u_mat (
    .clk, .rst_n,
    .in_valid(v[N]), .in_ready(m_ready), .sc_i(sc), .side_i(sd[N]),
    .out_valid, .out_ready, .out_row_number, .out_entry_col0, .out_entry_col1,
    .out_entry_col2, .out_offset_col3, .out_last_row
  );
endmodule
`default_nettype wire

// ===== verif/euler_rotation_about_center_unit_tb.sv =====
// testbench for the euler rotation unit: predicted 3x4 affine rows checked beat by beat
`timescale 1ns / 1ps
module euler_rotation_about_center_unit_tb;
  import erc_pkg::*;

  localparam int Steps     = 16;
  localparam int AngBits   = 16;
  localparam int CycleLimit = 200000;

  typedef struct {
    logic [15:0] ax, ay, az;
    logic signed [31:0] px, py, pz;
    logic [2:0] ord;
  } pose_t;

  typedef struct {
    logic [1:0] row;
    logic signed [31:0] c0, c1, c2, c3;
    logic last;
  } row_beat_t;

  typedef longint mat3_t [3][3];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  wire  in_ready;
  logic [15:0] in_angle_x = '0, in_angle_y = '0, in_angle_z = '0;
  logic signed [31:0] in_pivot_x = '0, in_pivot_y = '0, in_pivot_z = '0;
  logic [2:0] in_order_code = '0;
  wire  out_valid;
  logic out_ready = 1'b0;
  wire [1:0] out_row_number;
  wire signed [31:0] out_entry_col0, out_entry_col1, out_entry_col2, out_offset_col3;
  wire out_last_row;

  euler_rotation_about_center_unit u_top (.*);

  always #5 clk = ~clk;

  pose_t     pose_q[$];
  row_beat_t row_q[$];
  int  errors = 0;
  int  cycles = 0;
  bit  hold_send = 1'b0;
  bit  stim_done = 1'b0;

  // floor shift on a signed value; >>> on longint is arithmetic
  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  function automatic longint atan_turn(int i);
    longint tbl [30] = '{
      'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4, 'h028B0D43,
      'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2E,
      'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2F9,
      'h0000517C, 'h000028BE, 'h0000145F, 'h00000A2F, 'h00000517,
      'h0000028B, 'h00000145, 'h000000A2, 'h00000051, 'h00000028,
      'h00000014, 'h0000000A, 'h00000005, 'h00000002, 'h00000001};
    return tbl[i];
  endfunction

  // rotation-mode cordic with half-turn fold for the left half plane
  task automatic sine_cosine(input logic [15:0] ang, output longint s, output longint c);
    logic [31:0] u;
    bit flip;
    longint x, y, z, nx;
    u = 32'(ang) << (32 - AngBits);
    flip = (u[31:30] == 2'd1) || (u[31:30] == 2'd2);
    if (flip) u = u + 32'h80000000;
    z = longint'($signed(u));
    x = 652032874;
    y = 0;
    for (int i = 0; i < Steps; i++) begin
      if (z >= 0) begin
        nx = x - fshr(y, i); y = y + fshr(x, i); z -= atan_turn(i);
      end else begin
        nx = x + fshr(y, i); y = y - fshr(x, i); z += atan_turn(i);
      end
      x = nx;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clamp_unit(x);
    s = clamp_unit(y);
  endtask

  function automatic mat3_t mat_product(mat3_t a, mat3_t b);
    mat3_t p;
    longint acc;
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++) begin
        acc = 0;
        for (int m = 0; m < 3; m++) acc += a[r][m] * b[m][k];
        p[r][k] = clamp_unit(fshr(acc + (64'sd1 << 29), 30));
      end
    return p;
  endfunction

  // works out the three affine rows for one pose and queues them
  task automatic predict_rows(input pose_t p);
    longint sx, cx, sy, cy, sz, cz, acc, t;
    longint ctr [3];
    mat3_t rx, ry, rz, rot;
    row_beat_t b;
    longint one;
    one = 64'sd1073741824;
    sine_cosine(p.ax, sx, cx);
    sine_cosine(p.ay, sy, cy);
    sine_cosine(p.az, sz, cz);
    ctr[0] = p.px; ctr[1] = p.py; ctr[2] = p.pz;
    rx = '{'{one, 0, 0}, '{0, cx, -sx}, '{0, sx, cx}};
    ry = '{'{cy, 0, sy}, '{0, one, 0}, '{-sy, 0, cy}};
    rz = '{'{cz, -sz, 0}, '{sz, cz, 0}, '{0, 0, one}};
    case (p.ord)
      ORD_XZY: rot = mat_product(ry, mat_product(rz, rx));
      ORD_YXZ: rot = mat_product(rz, mat_product(rx, ry));
      ORD_YZX: rot = mat_product(rx, mat_product(rz, ry));
      ORD_ZXY: rot = mat_product(ry, mat_product(rx, rz));
      ORD_ZYX: rot = mat_product(rx, mat_product(ry, rz));
      default: rot = mat_product(rz, mat_product(ry, rx)); // unknown codes fall back to xyz
    endcase
    for (int r = 0; r < 3; r++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) acc += rot[r][k] * ctr[k];
      t = ctr[r] - fshr(acc + (64'sd1 << 29), 30);
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      b.row = r[1:0];
      b.c0 = rot[r][0][31:0];
      b.c1 = rot[r][1][31:0];
      b.c2 = rot[r][2][31:0];
      b.c3 = t[31:0];
      b.last = (r == 2);
      row_q.push_back(b);
    end
  endtask

  function automatic logic [31:0] rand_pivot();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 3)) << 14; // right angles
      1: return (16'($urandom_range(0, 3)) << 14) + 16'($urandom_range(0, 8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_pose(input logic [15:0] ax, ay, az, input logic [31:0] px, py, pz,
                            input logic [2:0] ord);
    pose_t p;
    p.ax = ax; p.ay = ay; p.az = az;
    p.px = px; p.py = py; p.pz = pz; p.ord = ord;
    pose_q.push_back(p);
  endtask

  // driver: draws a gap per beat, keeps valid and payload steady until accepted
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_rows('{in_angle_x, in_angle_y, in_angle_z, in_pivot_x, in_pivot_y,
                       in_pivot_z, in_order_code});
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pose_q.size() > 0 && !hold_send) begin
          in_valid      <= 1'b1;
          in_angle_x    <= pose_q[0].ax;
          in_angle_y    <= pose_q[0].ay;
          in_angle_z    <= pose_q[0].az;
          in_pivot_x    <= pose_q[0].px;
          in_pivot_y    <= pose_q[0].py;
          in_pivot_z    <= pose_q[0].pz;
          in_order_code <= pose_q[0].ord;
          void'(pose_q.pop_front());
          send_gap      <= $urandom_range(0, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each accepted row beat with the oldest prediction
  int stall_left = 0;
  int ready_gap = 0;
  row_beat_t want;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (row_q.size() == 0) begin
          $error("unexpected row beat: row %0d", out_row_number);
          errors++;
        end else begin
          want = row_q.pop_front();
          if (out_row_number !== want.row) begin
            $error("row_number exp %0d got %0d", want.row, out_row_number); errors++;
          end
          if (out_entry_col0 !== want.c0) begin
            $error("entry_col0 exp %0d got %0d", want.c0, out_entry_col0); errors++;
          end
          if (out_entry_col1 !== want.c1) begin
            $error("entry_col1 exp %0d got %0d", want.c1, out_entry_col1); errors++;
          end
          if (out_entry_col2 !== want.c2) begin
            $error("entry_col2 exp %0d got %0d", want.c2, out_entry_col2); errors++;
          end
          if (out_offset_col3 !== want.c3) begin
            $error("offset_col3 exp %0d got %0d", want.c3, out_offset_col3); errors++;
          end
          if (out_last_row !== want.last) begin
            $error("last_row exp %0d got %0d", want.last, out_last_row); errors++;
          end
        end
        ready_gap = $urandom_range(0, 3);
        if (ready_gap == 0) begin
          out_ready <= 1'b1;
        end else begin
          stall_left <= ready_gap - 1;
          out_ready  <= 1'b0;
        end
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [15:0] a;
    // zero angles, extremes of pivots, every order code
    for (int o = 0; o < 8; o++)
      queue_pose(16'd0, 16'd0, 16'd0, 32'h7FFFFFFF, 32'h80000000, 32'h00010000, 3'(o));
    // right-angle corners and quadrant edges where the cordic folds
    queue_pose(16'h4000, 16'h8000, 16'hC000, 32'h80000000, 32'h80000000, 32'h80000000, ORD_XYZ);
    queue_pose(16'h3FFF, 16'h7FFF, 16'hBFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, ORD_ZYX);
    queue_pose(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'h0, 32'h1, ORD_YXZ);
    queue_pose(16'h8001, 16'h4001, 16'hC001, 32'h0, 32'hFFFFFFFF, 32'h7FFFFFFF, ORD_ZXY);
    queue_pose(16'h2000, 16'h6000, 16'hA000, 32'h12345678, 32'h87654321, 32'h0, ORD_YZX);
    queue_pose(16'hE000, 16'h1000, 16'h5555, 32'hAAAAAAAA, 32'h55555555, 32'hFFFF0000, ORD_XZY);
    for (int i = 0; i < 6; i++) begin
      a = 16'(i) << 14;
      queue_pose(a, ~a, a ^ 16'h8000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 3'(i + 2));
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // let the directed set drain fully before random traffic
    wait (pose_q.size() == 0);
    hold_send = 1'b1;
    @(posedge clk);
    wait (!in_valid);
    wait (row_q.size() == 0);
    repeat (3) @(posedge clk);
    hold_send = 1'b0;
    for (int i = 0; i < 200; i++)
      queue_pose(rand_angle(), rand_angle(), rand_angle(), rand_pivot(), rand_pivot(),
                 rand_pivot(), 3'($urandom_range(0, 7)));
    wait (pose_q.size() == 0);
    @(posedge clk);
    wait (!in_valid);
    wait (row_q.size() == 0);
    repeat (Steps + 20) @(posedge clk);
    if (errors == 0 && row_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
